// ===== rtl/rrts_pkg.sv =====
// ----------------------------------------------------------------------------
// rrts_pkg
// Shared types and codes of the round-robin time-slice scheduler.
// ----------------------------------------------------------------------------
package rrts_pkg;

  localparam int IdW   = 4;
  localparam int WorkW = 16;
  localparam int OccW  = 5;

  typedef enum logic {
    CMD_ARRIVE = 1'b0,
    CMD_TICK   = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ARR_RD,
    S_ARR_COMMIT,
    S_REQUEUE,
    S_HEAD_RD,
    S_DISPATCH,
    S_WORK_RD,
    S_EXEC
  } state_e;

  typedef enum logic [3:0] {
    DP_NONE,
    DP_LOAD,
    DP_ARR_RD,
    DP_ARR_COMMIT,
    DP_REQUEUE,
    DP_HEAD_RD,
    DP_DISPATCH,
    DP_WORK_RD,
    DP_EXEC
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

endpackage

// ===== rtl/round_robin_time_slice_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// round_robin_time_slice_scheduler_core
// Round-robin scheduler with a FIFO ready queue and a per-task time quantum.
// ----------------------------------------------------------------------------
// usage
//   command channel: start is sampled while busy is low; command_i selects a
//   task arrival (task_id_i, burst_length_i) or one time tick
//   result channel: strobe_o is high for exactly one cycle per command, with
//   accepted/ran/running_task/work_left/completed/preempted/occupancy
//   alongside; the receiver cannot stall it
//   config channel: cfg_valid_i/cfg_ready_o/cfg_data_i write the quantum,
//   which applies from the next dispatch; the user must write it only while
//   the block is idle, which the block itself does not enforce
// timing
//   arrival: work read, commit; strobe in the cycle after the commit
//   tick: requeue, ring read, dispatch, work read, execute, with registered
//   ready-ring and remaining-work reads; a new command waits for busy low
// reset
//   queue empty, no task running, all remaining work zero, quantum 1
// ----------------------------------------------------------------------------
module round_robin_time_slice_scheduler_core #(
  parameter int MAX_TASKS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic                         command_i,
  input  logic [rrts_pkg::IdW-1:0]     task_id_i,
  input  logic [rrts_pkg::WorkW-1:0]   burst_length_i,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [rrts_pkg::WorkW-1:0]   cfg_data_i,
  output logic                         strobe_o,
  output logic                         accepted_o,
  output logic                         ran_o,
  output logic [rrts_pkg::IdW-1:0]     running_task_o,
  output logic [rrts_pkg::WorkW-1:0]   work_left_o,
  output logic                         completed_o,
  output logic                         preempted_o,
  output logic [rrts_pkg::OccW-1:0]    queue_occupancy_o
);
  import rrts_pkg::*;

  dp_cmd_t dp_cmd;
  logic    cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  rrts_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .command_i (command_i),
    .busy      (busy),
    .dp_cmd_o  (dp_cmd)
  );

  rrts_dpath #(
    .MAX_TASKS (MAX_TASKS)
  ) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .dp_cmd_i          (dp_cmd),
    .task_id_i         (task_id_i),
    .burst_length_i    (burst_length_i),
    .cfg_we_i          (cfg_we),
    .cfg_data_i        (cfg_data_i),
    .strobe_o          (strobe_o),
    .accepted_o        (accepted_o),
    .ran_o             (ran_o),
    .running_task_o    (running_task_o),
    .work_left_o       (work_left_o),
    .completed_o       (completed_o),
    .preempted_o       (preempted_o),
    .queue_occupancy_o (queue_occupancy_o)
  );

endmodule

// ===== rtl/rrts_ctrl.sv =====
// ----------------------------------------------------------------------------
// rrts_ctrl
// Sequencer of the scheduler: steps the datapath through an arrival or a tick.
// ----------------------------------------------------------------------------
module rrts_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  input  logic            command_i,
  output logic            busy,
  output rrts_pkg::dp_cmd_t dp_cmd_o
);
  import rrts_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d = (command_i == CMD_TICK) ? S_REQUEUE : S_ARR_RD;
        end
      end
      S_ARR_RD:     state_d = S_ARR_COMMIT;
      S_ARR_COMMIT: state_d = S_IDLE;
      S_REQUEUE:    state_d = S_HEAD_RD;
      S_HEAD_RD:    state_d = S_DISPATCH;
      S_DISPATCH:   state_d = S_WORK_RD;
      S_WORK_RD:    state_d = S_EXEC;
      S_EXEC:       state_d = S_IDLE;
      default:      state_d = S_IDLE;
    endcase
  end

  always_comb begin
    dp_cmd_o.op = DP_NONE;
    case (state_q)
      S_IDLE:       dp_cmd_o.op = start ? DP_LOAD : DP_NONE;
      S_ARR_RD:     dp_cmd_o.op = DP_ARR_RD;
      S_ARR_COMMIT: dp_cmd_o.op = DP_ARR_COMMIT;
      S_REQUEUE:    dp_cmd_o.op = DP_REQUEUE;
      S_HEAD_RD:    dp_cmd_o.op = DP_HEAD_RD;
      S_DISPATCH:   dp_cmd_o.op = DP_DISPATCH;
      S_WORK_RD:    dp_cmd_o.op = DP_WORK_RD;
      S_EXEC:       dp_cmd_o.op = DP_EXEC;
      default:      dp_cmd_o.op = DP_NONE;
    endcase
  end

  assign busy = (state_q != S_IDLE);

endmodule

// ===== rtl/rrts_dpath.sv =====
// ----------------------------------------------------------------------------
// rrts_dpath
// Datapath of the scheduler: ready ring, remaining-work memory, task state.
// ----------------------------------------------------------------------------
module rrts_dpath #(
  parameter int MAX_TASKS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  rrts_pkg::dp_cmd_t            dp_cmd_i,
  input  logic [rrts_pkg::IdW-1:0]     task_id_i,
  input  logic [rrts_pkg::WorkW-1:0]   burst_length_i,
  input  logic                         cfg_we_i,
  input  logic [rrts_pkg::WorkW-1:0]   cfg_data_i,
  output logic                         strobe_o,
  output logic                         accepted_o,
  output logic                         ran_o,
  output logic [rrts_pkg::IdW-1:0]     running_task_o,
  output logic [rrts_pkg::WorkW-1:0]   work_left_o,
  output logic                         completed_o,
  output logic                         preempted_o,
  output logic [rrts_pkg::OccW-1:0]    queue_occupancy_o
);
  import rrts_pkg::*;

  localparam int IdSlots = (MAX_TASKS < (1 << IdW)) ? MAX_TASKS : (1 << IdW);
  localparam int IdxW    = $clog2(IdSlots);
  localparam int PtrW    = $clog2(MAX_TASKS);
  localparam int CntW    = $clog2(MAX_TASKS + 1);

  // item latch
  logic [IdW-1:0]    id_q;
  logic [WorkW-1:0]  burst_q;

  // task state
  logic [WorkW-1:0]  quantum_q;
  logic [PtrW-1:0]   head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [IdW-1:0]    cur_q, cur_d;
  logic              running_q, running_d;
  logic [WorkW-1:0]  slice_q, slice_d;
  logic              requeue_q, requeue_d;

  // memories
  logic [IdW-1:0]    ring_mem [MAX_TASKS];
  logic [IdW-1:0]    ring_rd_q;
  logic              ring_we;
  logic [IdW-1:0]    ring_wdata;
  logic [WorkW-1:0]  work_mem [IdSlots];
  logic [IdSlots-1:0] work_vld_q;
  logic [WorkW-1:0]  work_rd_q;
  logic              work_rd_vld_q;
  logic [IdxW-1:0]   work_raddr, work_waddr;
  logic              work_we;
  logic [WorkW-1:0]  work_wdata;
  logic [WorkW-1:0]  work_cur;

  // results
  logic              strobe_q;
  logic              accepted_q, accepted_d;
  logic              ran_q, ran_d;
  logic [IdW-1:0]    task_q, task_d;
  logic [WorkW-1:0]  left_q, left_d;
  logic              done_q, done_d;
  logic              pre_q, pre_d;
  logic [CntW-1:0]   occ_q;
  logic [31:0]       occ_ext;

  logic              id_ok, arr_ok, not_full;
  logic [WorkW-1:0]  work_dec, slice_dec;
  logic              out_load;

  assign work_cur  = work_rd_vld_q ? work_rd_q : '0;
  assign id_ok     = ({1'b0, id_q} < (IdW + 1)'(IdSlots));
  assign not_full  = (count_q < CntW'(MAX_TASKS));
  assign arr_ok    = (burst_q != '0) && id_ok && (work_cur == '0) && not_full;
  assign work_dec  = work_cur - 1'b1;
  assign slice_dec = slice_q - 1'b1;
  assign out_load  = (dp_cmd_i.op == DP_ARR_COMMIT) || (dp_cmd_i.op == DP_EXEC);

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == PtrW'(MAX_TASKS - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    head_d     = head_q;
    tail_d     = tail_q;
    count_d    = count_q;
    cur_d      = cur_q;
    running_d  = running_q;
    slice_d    = slice_q;
    requeue_d  = requeue_q;
    ring_we    = 1'b0;
    ring_wdata = cur_q;
    work_raddr = cur_q[IdxW-1:0];
    work_waddr = cur_q[IdxW-1:0];
    work_we    = 1'b0;
    work_wdata = work_dec;
    accepted_d = 1'b0;
    ran_d      = 1'b0;
    task_d     = '0;
    left_d     = '0;
    done_d     = 1'b0;
    pre_d      = 1'b0;
    case (dp_cmd_i.op)
      DP_ARR_RD: begin
        work_raddr = id_q[IdxW-1:0];
      end
      DP_ARR_COMMIT: begin
        accepted_d = arr_ok;
        if (arr_ok) begin
          work_we    = 1'b1;
          work_waddr = id_q[IdxW-1:0];
          work_wdata = burst_q;
          ring_we    = 1'b1;
          ring_wdata = id_q;
          tail_d     = ptr_inc(tail_q);
          count_d    = count_q + 1'b1;
        end
      end
      DP_REQUEUE: begin
        if (requeue_q) begin
          requeue_d = 1'b0;
          if (not_full) begin
            ring_we = 1'b1;
            tail_d  = ptr_inc(tail_q);
            count_d = count_q + 1'b1;
          end
        end
      end
      DP_DISPATCH: begin
        if (!running_q && (count_q != '0)) begin
          cur_d     = ring_rd_q;
          head_d    = ptr_inc(head_q);
          count_d   = count_q - 1'b1;
          slice_d   = quantum_q;
          running_d = 1'b1;
        end
      end
      DP_EXEC: begin
        if (running_q) begin
          work_we = 1'b1;
          ran_d   = 1'b1;
          task_d  = cur_q;
          left_d  = work_dec;
          slice_d = slice_dec;
          if (work_dec == '0) begin
            done_d    = 1'b1;
            slice_d   = '0;
            running_d = 1'b0;
          end else if (slice_dec == '0) begin
            pre_d     = 1'b1;
            requeue_d = 1'b1;
            running_d = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quantum_q  <= WorkW'(1);
      head_q     <= '0;
      tail_q     <= '0;
      count_q    <= '0;
      cur_q      <= '0;
      running_q  <= 1'b0;
      slice_q    <= '0;
      requeue_q  <= 1'b0;
      work_vld_q <= '0;
      strobe_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        quantum_q <= cfg_data_i;
      end
      head_q    <= head_d;
      tail_q    <= tail_d;
      count_q   <= count_d;
      cur_q     <= cur_d;
      running_q <= running_d;
      slice_q   <= slice_d;
      requeue_q <= requeue_d;
      if (work_we) begin
        work_vld_q[work_waddr] <= 1'b1;
      end
      strobe_q  <= out_load;
    end
  end

  // item latch and result registers
  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.op == DP_LOAD) begin
      id_q    <= task_id_i;
      burst_q <= burst_length_i;
    end
    if (out_load) begin
      accepted_q <= accepted_d;
      ran_q      <= ran_d;
      task_q     <= task_d;
      left_q     <= left_d;
      done_q     <= done_d;
      pre_q      <= pre_d;
      occ_q      <= count_d;
    end
  end

  // ready ring
  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[tail_q] <= ring_wdata;
    end
    if (dp_cmd_i.op == DP_HEAD_RD) begin
      ring_rd_q <= ring_mem[head_q];
    end
  end

  // remaining work per task
  always_ff @(posedge clk_i) begin
    if (work_we) begin
      work_mem[work_waddr] <= work_wdata;
    end
    if ((dp_cmd_i.op == DP_ARR_RD) || (dp_cmd_i.op == DP_WORK_RD)) begin
      work_rd_q     <= work_mem[work_raddr];
      work_rd_vld_q <= work_vld_q[work_raddr];
    end
  end

  assign occ_ext           = 32'(occ_q);
  assign strobe_o          = strobe_q;
  assign accepted_o        = accepted_q;
  assign ran_o             = ran_q;
  assign running_task_o    = task_q;
  assign work_left_o       = left_q;
  assign completed_o       = done_q;
  assign preempted_o       = pre_q;
  assign queue_occupancy_o = occ_ext[OccW-1:0];

  ap_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_TASKS))
    else $error("ready ring count beyond capacity");

  ap_done_or_pre: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_q |-> !(done_q && pre_q))
    else $error("completion and preemption together");

  ap_arr_or_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_q |-> !(accepted_q && ran_q))
    else $error("arrival and execution in one result");

  ap_pre_requeue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_q && pre_q) |-> requeue_q)
    else $error("preempted task not marked for requeue");

  ap_run_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(running_q && requeue_q))
    else $error("task running while requeue pending");

endmodule
